// File: hdl/ntl_pkg.sv
// Shared constants, codes and types of the no-three-in-line placer.
// No dependencies.
package ntl_pkg;
  localparam int MAX_GRID   = 64;
  localparam int MAX_CHOSEN = 128;
  localparam int COORD_W    = $clog2(MAX_GRID);
  localparam int ADDR_W     = 2 * COORD_W;
  localparam int MAP_DEPTH  = MAX_GRID * MAX_GRID;
  localparam int LIST_AW    = $clog2(MAX_CHOSEN);
  localparam int CNT_W      = 8;
  localparam int AVAIL_W    = 13;
  localparam int SIDE_W     = 7;
  localparam int PICK_W     = 16;
  localparam int STEP_W     = COORD_W + 2;

  typedef enum logic [1:0] {
    ST_PLACED  = 2'd0,
    ST_REJECT  = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_CLEARED = 2'd3
  } status_t;

  localparam logic [1:0] FN_CLEAR = 2'd0;
  localparam logic [1:0] FN_GIVEN = 2'd1;
  localparam logic [1:0] FN_RANK  = 2'd2;

  localparam logic CFG_GRID = 1'b0;
  localparam logic CFG_DIAG = 1'b1;
endpackage

// File: hdl/ntl_if.sv
// Channel interfaces of the placer: command beats, result beats, register writes.
// Depends on ntl_pkg.
interface ntl_req_if import ntl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        func;
  logic [COORD_W-1:0] point_x;
  logic [COORD_W-1:0] point_y;
  logic [PICK_W-1:0] random_pick;
  modport source (output valid, func, point_x, point_y, random_pick, input ready);
  modport sink (input valid, func, point_x, point_y, random_pick, output ready);
endinterface

interface ntl_rsp_if import ntl_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [COORD_W-1:0] placed_x;
  logic [COORD_W-1:0] placed_y;
  logic               mirror_placed;
  logic [CNT_W-1:0]   chosen_count;
  logic [AVAIL_W-1:0] available_count;
  modport source (output valid, status, placed_x, placed_y, mirror_placed, chosen_count,
                  available_count, input ready);
  modport sink (input valid, status, placed_x, placed_y, mirror_placed, chosen_count,
                available_count, output ready);
endinterface

interface ntl_cfg_if import ntl_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              index;
  logic [SIDE_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: hdl/ntl_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module ntl_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: hdl/ntl_div.sv
// Restoring divider, one quotient bit per cycle; shared by modulo, gcd and step reduction.
// Depends on ntl_pkg.
module ntl_div import ntl_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [PICK_W-1:0]  dividend,
  input  logic [AVAIL_W-1:0] divisor,
  output logic               done,
  output logic [PICK_W-1:0]  quo,
  output logic [AVAIL_W-1:0] rem
);
  logic                      busy;
  logic [$clog2(PICK_W)-1:0] cnt;
  logic [AVAIL_W-1:0]        d;
  logic [AVAIL_W:0]          trial;

  assign trial = {rem, quo[PICK_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        quo  <= dividend;
        rem  <= '0;
        d    <= divisor;
      end else if (busy) begin
        if (trial >= {1'b0, d}) begin
          rem <= AVAIL_W'(trial - {1'b0, d});
          quo <= {quo[PICK_W-2:0], 1'b1};
        end else begin
          rem <= trial[AVAIL_W-1:0];
          quo <= {quo[PICK_W-2:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
        if (cnt == '1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

// File: hdl/no_three_in_line_greedy_placer.sv
// No-three-in-line greedy placer: sequencer around one availability map, one chosen list
// and one shared divider. Depends on ntl_pkg, ntl_if, ntl_ram, ntl_div.
//
// One command beat at a time. A clear (and reset, and every grid_used write) sweeps the
// 4096-entry map one cell a cycle, with commands held off. A ranked place first runs a
// modulo on the divider and then scans the map one cell a cycle, up to the whole map.
// Each placement then visits the chosen points one by one: each runs a gcd on the divider
// (one division per remainder step, then two quotients) and walks the line through the new
// point cell by cell, bounded by the single map port. A result waits in an output register;
// the next command is taken while it waits.
module no_three_in_line_greedy_placer import ntl_pkg::*; (
  input logic     clk,
  input logic     rst,
  ntl_req_if.sink   req,
  ntl_rsp_if.source rsp,
  ntl_cfg_if.sink   cfg
);
  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_PW, S_PCHK, S_MODW, S_SCAN, S_LOOP, S_QW, S_QDAT, S_GCD, S_GCDW,
    S_DQ1, S_DQ2, S_LADR, S_LWAIT, S_LCHK, S_APPEND, S_KW, S_KCHK, S_FIN
  } state_t;

  state_t              state;
  logic [SIDE_W-1:0]   grid_used;
  logic                diag_symmetric;
  logic [SIDE_W-1:0]   side;
  logic [2*SIDE_W-1:0] side_sq;
  logic [ADDR_W-1:0]   clr_addr;
  logic                clr_reply;
  logic [CNT_W-1:0]    chosen_total;
  logic [AVAIL_W-1:0]  avail_total;
  logic [ADDR_W-1:0]   map_ra;
  logic                map_we;
  logic [ADDR_W-1:0]   map_wa;
  logic                map_wd;
  logic                map_rd;
  logic                list_we;
  logic [2*COORD_W-1:0] list_rd;
  logic [CNT_W-1:0]    k;
  logic [COORD_W-1:0]  pick_x, pick_y, cur_x, cur_y;
  logic                phase, mirror, line_diag, dir;
  status_t             res_status;
  logic                div_start, div_done;
  logic [PICK_W-1:0]   div_a, div_quo;
  logic [AVAIL_W-1:0]  div_b, div_rem;
  logic [AVAIL_W-1:0]  rank, seen;
  logic                scan_iss, scan_v;
  logic [ADDR_W-1:0]   scan_prev;
  logic [COORD_W-1:0]  ga, gb, mag_run, mag_rise, mag_step_run;
  logic                neg_run, neg_rise;
  logic [STEP_W-1:0]   srun, srise, wx, wy;
  logic [COORD_W:0]    run_d, rise_d;
  logic                w_inside, clr_in;
  logic                out_valid;
  status_t             out_status;
  logic [COORD_W-1:0]  out_x, out_y;
  logic                out_mirror;
  logic [CNT_W-1:0]    out_chosen;
  logic [AVAIL_W-1:0]  out_avail;

  assign side = (grid_used == '0) ? SIDE_W'(1) :
                (grid_used > SIDE_W'(MAX_GRID)) ? SIDE_W'(MAX_GRID) : grid_used;
  assign side_sq = side * side;
  assign clr_in = ({1'b0, clr_addr[ADDR_W-1:COORD_W]} < side) &&
                  ({1'b0, clr_addr[COORD_W-1:0]} < side);
  assign w_inside = !wx[STEP_W-1] && !wy[STEP_W-1] &&
                    (wx[SIDE_W-1:0] < side) && (wy[SIDE_W-1:0] < side);
  assign run_d  = {1'b0, cur_x} - {1'b0, list_rd[2*COORD_W-1:COORD_W]};
  assign rise_d = {1'b0, cur_y} - {1'b0, list_rd[COORD_W-1:0]};

  always_comb begin
    map_we = 1'b0;
    map_wa = map_ra;
    map_wd = 1'b0;
    unique case (state)
      S_CLR: begin
        map_we = 1'b1;
        map_wa = clr_addr;
        map_wd = clr_in;
      end
      S_LCHK, S_KCHK: map_we = map_rd;
      default: map_we = 1'b0;
    endcase
  end

  assign list_we = (state == S_APPEND) && (chosen_total < CNT_W'(MAX_CHOSEN));

  ntl_ram #(.WIDTH(1), .DEPTH(MAP_DEPTH)) u_map (
    .clk(clk), .we(map_we), .waddr(map_wa), .wdata(map_wd), .raddr(map_ra), .rdata(map_rd)
  );

  ntl_ram #(.WIDTH(2*COORD_W), .DEPTH(MAX_CHOSEN)) u_list (
    .clk(clk), .we(list_we), .waddr(chosen_total[LIST_AW-1:0]), .wdata({cur_x, cur_y}),
    .raddr(k[LIST_AW-1:0]), .rdata(list_rd)
  );

  ntl_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_a), .divisor(div_b),
    .done(div_done), .quo(div_quo), .rem(div_rem)
  );

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign rsp.valid = out_valid;
  assign rsp.status = out_status;
  assign rsp.placed_x = out_x;
  assign rsp.placed_y = out_y;
  assign rsp.mirror_placed = out_mirror;
  assign rsp.chosen_count = out_chosen;
  assign rsp.available_count = out_avail;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_CLR;
      grid_used      <= SIDE_W'(16);
      diag_symmetric <= 1'b0;
      clr_addr       <= '0;
      clr_reply      <= 1'b0;
      chosen_total   <= '0;
      avail_total    <= '0;
      out_valid      <= 1'b0;
      div_start      <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (out_valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == '1) begin
            chosen_total <= '0;
            avail_total  <= side_sq[AVAIL_W-1:0];
            res_status   <= ST_CLEARED;
            state        <= clr_reply ? S_FIN : S_IDLE;
          end
        end
        S_IDLE: begin
          phase     <= 1'b0;
          mirror    <= 1'b0;
          line_diag <= 1'b0;
          k         <= '0;
          if (req.valid) begin
            case (req.func)
              FN_CLEAR: begin
                clr_addr  <= '0;
                clr_reply <= 1'b1;
                state     <= S_CLR;
              end
              FN_GIVEN: begin
                pick_x <= req.point_x;
                pick_y <= req.point_y;
                cur_x  <= req.point_x;
                cur_y  <= req.point_y;
                map_ra <= {req.point_x, req.point_y};
                if (({1'b0, req.point_x} < side) && ({1'b0, req.point_y} < side)) begin
                  state <= S_PW;
                end else begin
                  res_status <= ST_REJECT;
                  state      <= S_FIN;
                end
              end
              FN_RANK: begin
                if (avail_total == '0) begin
                  res_status <= ST_EMPTY;
                  state      <= S_FIN;
                end else begin
                  div_a     <= req.random_pick;
                  div_b     <= avail_total;
                  div_start <= 1'b1;
                  state     <= S_MODW;
                end
              end
              default: begin
                res_status <= ST_REJECT;
                state      <= S_FIN;
              end
            endcase
          end
        end
        S_PW: state <= S_PCHK;
        S_PCHK: begin
          if (map_rd) begin
            state <= S_LOOP;
          end else begin
            res_status <= ST_REJECT;
            state      <= S_FIN;
          end
        end
        S_MODW: begin
          if (div_done) begin
            rank     <= div_rem;
            seen     <= '0;
            map_ra   <= '0;
            scan_iss <= 1'b1;
            scan_v   <= 1'b0;
            state    <= S_SCAN;
          end
        end
        S_SCAN: begin
          scan_prev <= map_ra;
          scan_v    <= scan_iss;
          if (scan_iss) begin
            if (map_ra == '1) begin
              scan_iss <= 1'b0;
            end else begin
              map_ra <= map_ra + 1'b1;
            end
          end
          if (scan_v && map_rd) begin
            if (seen == rank) begin
              pick_x <= scan_prev[ADDR_W-1:COORD_W];
              pick_y <= scan_prev[COORD_W-1:0];
              cur_x  <= scan_prev[ADDR_W-1:COORD_W];
              cur_y  <= scan_prev[COORD_W-1:0];
              state  <= S_LOOP;
            end else begin
              seen <= seen + 1'b1;
            end
          end else if (!scan_v && !scan_iss) begin
            res_status <= ST_EMPTY;
            state      <= S_FIN;
          end
        end
        S_LOOP: state <= (k < chosen_total) ? S_QW : S_APPEND;
        S_QW: state <= S_QDAT;
        S_QDAT: begin
          if (run_d == '0 && rise_d == '0) begin
            k     <= k + 1'b1;
            state <= S_LOOP;
          end else begin
            neg_run  <= run_d[COORD_W];
            neg_rise <= rise_d[COORD_W];
            mag_run  <= run_d[COORD_W] ? COORD_W'(-run_d) : run_d[COORD_W-1:0];
            mag_rise <= rise_d[COORD_W] ? COORD_W'(-rise_d) : rise_d[COORD_W-1:0];
            ga       <= run_d[COORD_W] ? COORD_W'(-run_d) : run_d[COORD_W-1:0];
            gb       <= rise_d[COORD_W] ? COORD_W'(-rise_d) : rise_d[COORD_W-1:0];
            state    <= S_GCD;
          end
        end
        S_GCD: begin
          div_start <= 1'b1;
          if (gb == '0) begin
            div_a <= PICK_W'(mag_run);
            div_b <= AVAIL_W'(ga);
            state <= S_DQ1;
          end else begin
            div_a <= PICK_W'(ga);
            div_b <= AVAIL_W'(gb);
            state <= S_GCDW;
          end
        end
        S_GCDW: begin
          if (div_done) begin
            ga    <= gb;
            gb    <= div_rem[COORD_W-1:0];
            state <= S_GCD;
          end
        end
        S_DQ1: begin
          if (div_done) begin
            mag_step_run <= div_quo[COORD_W-1:0];
            div_a        <= PICK_W'(mag_rise);
            div_start    <= 1'b1;
            state        <= S_DQ2;
          end
        end
        S_DQ2: begin
          if (div_done) begin
            srun  <= neg_run ? STEP_W'(-{2'b00, mag_step_run}) : {2'b00, mag_step_run};
            srise <= neg_rise ? STEP_W'(-{2'b00, div_quo[COORD_W-1:0]}) :
                                {2'b00, div_quo[COORD_W-1:0]};
            wx    <= {2'b00, cur_x} +
                     (neg_run ? STEP_W'(-{2'b00, mag_step_run}) : {2'b00, mag_step_run});
            wy    <= {2'b00, cur_y} +
                     (neg_rise ? STEP_W'(-{2'b00, div_quo[COORD_W-1:0]}) :
                                 {2'b00, div_quo[COORD_W-1:0]});
            dir   <= 1'b0;
            state <= S_LADR;
          end
        end
        S_LADR: begin
          if (w_inside) begin
            map_ra <= {wx[COORD_W-1:0], wy[COORD_W-1:0]};
            state  <= S_LWAIT;
          end else if (!dir) begin
            dir   <= 1'b1;
            srun  <= STEP_W'(-srun);
            srise <= STEP_W'(-srise);
            wx    <= {2'b00, cur_x} - srun;
            wy    <= {2'b00, cur_y} - srise;
          end else if (line_diag) begin
            res_status <= ST_PLACED;
            state      <= S_FIN;
          end else begin
            k     <= k + 1'b1;
            state <= S_LOOP;
          end
        end
        S_LWAIT: state <= S_LCHK;
        S_LCHK: begin
          if (map_rd) begin
            avail_total <= avail_total - 1'b1;
          end
          wx    <= wx + srun;
          wy    <= wy + srise;
          state <= S_LADR;
        end
        S_APPEND: begin
          if (chosen_total < CNT_W'(MAX_CHOSEN)) begin
            chosen_total <= chosen_total + 1'b1;
          end
          map_ra <= {cur_x, cur_y};
          state  <= S_KW;
        end
        S_KW: state <= S_KCHK;
        S_KCHK: begin
          if (map_rd) begin
            avail_total <= avail_total - 1'b1;
          end
          k <= '0;
          if (!phase && diag_symmetric) begin
            if (cur_x == cur_y) begin
              line_diag <= 1'b1;
              srun      <= '1;
              srise     <= STEP_W'(1);
              wx        <= {2'b00, cur_x} - STEP_W'(1);
              wy        <= {2'b00, cur_y} + STEP_W'(1);
              dir       <= 1'b0;
              state     <= S_LADR;
            end else begin
              phase  <= 1'b1;
              mirror <= 1'b1;
              cur_x  <= cur_y;
              cur_y  <= cur_x;
              state  <= S_LOOP;
            end
          end else begin
            res_status <= ST_PLACED;
            state      <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid || rsp.ready) begin
            out_valid  <= 1'b1;
            out_status <= res_status;
            out_x      <= (res_status == ST_PLACED) ? pick_x : '0;
            out_y      <= (res_status == ST_PLACED) ? pick_y : '0;
            out_mirror <= (res_status == ST_PLACED) && mirror;
            out_chosen <= chosen_total;
            out_avail  <= avail_total;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (cfg.valid) begin
        unique case (cfg.index)
          CFG_GRID: begin
            grid_used <= cfg.data;
            clr_addr  <= '0;
            clr_reply <= 1'b0;
            state     <= S_CLR;
          end
          CFG_DIAG: diag_symmetric <= cfg.data[0];
          default: diag_symmetric <= diag_symmetric;
        endcase
      end
    end
  end
endmodule

// File: test/no_three_in_line_greedy_placer_tb.sv
// Self-checking testbench for the no-three-in-line greedy placer.
// A scoreboard class mirrors the grid, the chosen list and the counters and checks every
// result beat. Depends on ntl_pkg, ntl_if and the placer RTL.
module no_three_in_line_greedy_placer_tb;
  import ntl_pkg::*;

  localparam logic [1:0] FN_UNUSED = 2'd3;

  typedef struct packed {
    status_t            status;
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
    logic               mirror;
    logic [CNT_W-1:0]   chosen;
    logic [AVAIL_W-1:0] avail;
  } placement_t;

  class placer_scoreboard;
    bit          open_cell[MAP_DEPTH];
    int          list_x[MAX_CHOSEN];
    int          list_y[MAX_CHOSEN];
    int          n_chosen;
    int          n_open;
    int          grid_reg;
    bit          mirror_mode;
    placement_t  pending[$];
    int          errors;

    function new();
      grid_reg = 16;
      mirror_mode = 0;
      errors = 0;
      wipe_grid();
    endfunction

    function int side();
      if (grid_reg < 1) return 1;
      if (grid_reg > MAX_GRID) return MAX_GRID;
      return grid_reg;
    endfunction

    function void wipe_grid();
      int n;
      n = side();
      foreach (open_cell[i]) open_cell[i] = ((i / MAX_GRID) < n) && ((i % MAX_GRID) < n);
      n_chosen = 0;
      n_open = n * n;
    endfunction

    function void write_reg(logic idx, logic [SIDE_W-1:0] val);
      if (idx == CFG_GRID) begin
        grid_reg = val;
        wipe_grid();
      end else begin
        mirror_mode = val[0];
      end
    endfunction

    function bit on_grid(int x, int y, int n);
      return x >= 0 && x < n && y >= 0 && y < n;
    endfunction

    function void block_cell(int x, int y);
      if (open_cell[x * MAX_GRID + y]) begin
        open_cell[x * MAX_GRID + y] = 0;
        n_open--;
      end
    endfunction

    function void block_line(int px, int py, int dy, int dx, int n);
      int x, y;
      x = px + dx;
      y = py + dy;
      while (on_grid(x, y, n)) begin
        block_cell(x, y);
        x += dx;
        y += dy;
      end
      x = px - dx;
      y = py - dy;
      while (on_grid(x, y, n)) begin
        block_cell(x, y);
        x -= dx;
        y -= dy;
      end
    endfunction

    function int common_div(int a, int b);
      int t;
      while (b != 0) begin
        t = a % b;
        a = b;
        b = t;
      end
      return a;
    endfunction

    function void take_point(int px, int py, int n);
      int dx, dy, g;
      for (int k = 0; k < n_chosen; k++) begin
        dx = px - list_x[k];
        dy = py - list_y[k];
        if (dx != 0 || dy != 0) begin
          g = common_div(dx < 0 ? -dx : dx, dy < 0 ? -dy : dy);
          block_line(px, py, dy / g, dx / g, n);
        end
      end
      if (n_chosen < MAX_CHOSEN) begin
        list_x[n_chosen] = px;
        list_y[n_chosen] = py;
        n_chosen++;
      end
      block_cell(px, py);
    endfunction

    function void note_command(logic [1:0] fn, int x, int y, int pick);
      placement_t r;
      int n, px, py, rank, seen;
      bit go, found;
      n = side();
      px = 0;
      py = 0;
      go = 0;
      r = '0;
      r.status = ST_REJECT;
      if (fn == FN_CLEAR) begin
        wipe_grid();
        r.status = ST_CLEARED;
      end else if (fn == FN_GIVEN) begin
        px = x;
        py = y;
        go = on_grid(px, py, n) && open_cell[px * MAX_GRID + py];
      end else if (fn == FN_RANK) begin
        r.status = ST_EMPTY;
        if (n_open != 0) begin
          rank = pick % n_open;
          seen = 0;
          found = 0;
          for (int i = 0; i < n && !found; i++)
            for (int j = 0; j < n && !found; j++)
              if (open_cell[i * MAX_GRID + j]) begin
                if (seen == rank) begin
                  px = i;
                  py = j;
                  found = 1;
                end
                seen++;
              end
          go = found;
        end
      end
      if (go) begin
        take_point(px, py, n);
        if (mirror_mode) begin
          if (px == py) block_line(px, py, 1, -1, n);
          else begin
            take_point(py, px, n);
            r.mirror = 1;
          end
        end
        r.status = ST_PLACED;
        r.px = COORD_W'(px);
        r.py = COORD_W'(py);
      end
      r.chosen = CNT_W'(n_chosen);
      r.avail = AVAIL_W'(n_open);
      pending = {pending, r};
    endfunction

    function void check_result(placement_t got);
      placement_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result beat %p", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status)
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
      if (got.px !== want.px)
        $display("%0t: placed_x expected %0d actual %0d", $time, want.px, got.px);
      if (got.py !== want.py)
        $display("%0t: placed_y expected %0d actual %0d", $time, want.py, got.py);
      if (got.mirror !== want.mirror)
        $display("%0t: mirror_placed expected %0d actual %0d", $time, want.mirror, got.mirror);
      if (got.chosen !== want.chosen)
        $display("%0t: chosen_count expected %0d actual %0d", $time, want.chosen, got.chosen);
      if (got.avail !== want.avail)
        $display("%0t: available_count expected %0d actual %0d", $time, want.avail,
                 got.avail);
      if (got !== want) errors++;
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  bit   hold_off = 0;
  placer_scoreboard sb = new();

  ntl_req_if req();
  ntl_rsp_if rsp();
  ntl_cfg_if cfg();

  no_three_in_line_greedy_placer i_dut (.clk(clk), .rst(rst), .req(req), .rsp(rsp), .cfg(cfg));

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  always @(posedge clk) begin
    placement_t got;
    if (!rst && rsp.valid && rsp.ready) begin
      got.status = status_t'(rsp.status);
      got.px = rsp.placed_x;
      got.py = rsp.placed_y;
      got.mirror = rsp.mirror_placed;
      got.chosen = rsp.chosen_count;
      got.avail = rsp.available_count;
      sb.check_result(got);
    end
    if (!rst && req.valid && req.ready)
      sb.note_command(req.func, int'(req.point_x), int'(req.point_y), int'(req.random_pick));
  end

  initial begin
    int period, duty, cyc;
    rsp.ready = 0;
    period = 1;
    duty = 1;
    cyc = 0;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        rsp.ready <= 0;
        repeat (6000) @(negedge clk);
        hold_off = 0;
      end else begin
        if (cyc % 150 == 0) begin
          period = $urandom_range(1, 6);
          duty = $urandom_range(1, period);
        end
        rsp.ready <= (cyc % period) < duty;
        cyc++;
      end
    end
  end

  task automatic send_cmd(logic [1:0] fn, int x, int y, int pick);
    req.valid <= 1;
    req.func <= fn;
    req.point_x <= COORD_W'(x);
    req.point_y <= COORD_W'(y);
    req.random_pick <= PICK_W'(pick);
    do @(posedge clk); while (!req.ready);
    @(negedge clk);
    if ($urandom_range(0, 3) == 0) begin
      req.valid <= 0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
  endtask

  task automatic write_reg(logic idx, logic [SIDE_W-1:0] val);
    req.valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg.valid <= 1;
    cfg.index <= idx;
    cfg.data <= val;
    do @(posedge clk); while (!cfg.ready);
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg.valid <= 0;
  endtask

  task automatic random_cmds(int count);
    int n, sel;
    n = sb.side();
    repeat (count) begin
      sel = $urandom_range(0, 99);
      if (sel < 55) send_cmd(FN_RANK, $urandom_range(0, 63), $urandom_range(0, 63),
                             $urandom_range(0, 65535));
      else if (sel < 80) send_cmd(FN_GIVEN, $urandom_range(0, n - 1), $urandom_range(0, n - 1),
                                  $urandom_range(0, 65535));
      else if (sel < 88) send_cmd(FN_GIVEN, $urandom_range(0, 63), $urandom_range(0, 63),
                                  $urandom_range(0, 65535));
      else if (sel < 94) send_cmd(FN_CLEAR, $urandom_range(0, 63), $urandom_range(0, 63),
                                  $urandom_range(0, 65535));
      else send_cmd(FN_UNUSED, $urandom_range(0, 63), $urandom_range(0, 63),
                    $urandom_range(0, 65535));
    end
  endtask

  initial begin
    req.valid = 0;
    req.func = FN_CLEAR;
    req.point_x = 0;
    req.point_y = 0;
    req.random_pick = 0;
    cfg.valid = 0;
    cfg.index = CFG_GRID;
    cfg.data = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 0;

    send_cmd(FN_GIVEN, 0, 0, 0);
    send_cmd(FN_GIVEN, 15, 15, 0);
    send_cmd(FN_GIVEN, 0, 0, 0);
    send_cmd(FN_GIVEN, 63, 63, 65535);
    send_cmd(FN_UNUSED, 7, 7, 0);
    send_cmd(FN_RANK, 0, 0, 0);
    send_cmd(FN_RANK, 0, 0, 65535);
    send_cmd(FN_CLEAR, 0, 0, 0);
    send_cmd(FN_RANK, 63, 63, 12345);
    write_reg(CFG_GRID, 1);
    send_cmd(FN_RANK, 0, 0, 9);
    send_cmd(FN_RANK, 0, 0, 9);
    send_cmd(FN_GIVEN, 0, 0, 0);
    write_reg(CFG_GRID, 0);
    send_cmd(FN_GIVEN, 0, 0, 0);
    send_cmd(FN_RANK, 0, 0, 3);
    write_reg(CFG_GRID, 8);
    write_reg(CFG_DIAG, 7'h7f);
    send_cmd(FN_GIVEN, 3, 3, 0);
    send_cmd(FN_GIVEN, 1, 5, 0);
    send_cmd(FN_GIVEN, 5, 1, 0);
    hold_off = 1;
    random_cmds(40);
    write_reg(CFG_GRID, 64);
    write_reg(CFG_DIAG, 7'h00);
    send_cmd(FN_GIVEN, 63, 63, 0);
    send_cmd(FN_GIVEN, 0, 63, 0);
    random_cmds(4);
    write_reg(CFG_GRID, 127);
    write_reg(CFG_DIAG, 7'h01);
    random_cmds(3);
    write_reg(CFG_GRID, 12);
    write_reg(CFG_DIAG, 7'h7e);
    random_cmds(45);
    write_reg(CFG_GRID, 16);
    write_reg(CFG_DIAG, 7'h01);
    random_cmds(30);

    req.valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (sb.errors == 0)
      $display("no_three_in_line_greedy_placer_tb: done, clean");
    else
      $display("no_three_in_line_greedy_placer_tb: done, errors");
    $finish;
  end

  initial begin
    #1_000_000_000;
    $display("no_three_in_line_greedy_placer_tb: done, errors");
    $finish;
  end
endmodule
